@@ design/acbc_pkg.sv @@
package acbc_pkg;

  localparam int POOL_DEPTH_DEF = 256;
  localparam int MAX_PICKS = 64;
  localparam int HIT_COUNT_TOL = 12;

  localparam int FP_W = 21;
  localparam int AGE_W = 8;
  localparam int CNT_W = 7;
  localparam int TSUM_W = 30;
  localparam int SUM_W = 32;
  localparam int IDXO_W = 8;
  localparam int CFG_W = 30;
  localparam int CFG_IDX_W = 2;

  localparam logic KIND_COMPOSE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AGE_CAP      = 2'd0,
    REG_COUNT_TARGET = 2'd1,
    REG_TARGET_SUM   = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic start;
    logic div_start;
    logic scan_start;
    logic pick;
    logic emit_final;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic scan_done;
    logic sel_found;
    logic more;
    logic pend_valid;
    logic out_busy;
  } sts_t;

endpackage

@@ design/acbc_req_if.sv @@
interface acbc_req_if;
  import acbc_pkg::*;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [FP_W-1:0]    entry_footprint;
  logic [AGE_W-1:0]   entry_age;

  modport source (output valid, kind, entry_footprint, entry_age, input ready);
  modport sink (input valid, kind, entry_footprint, entry_age, output ready);
endinterface

@@ design/acbc_rsp_if.sv @@
interface acbc_rsp_if;
  import acbc_pkg::*;
  logic               valid;
  logic               ready;
  logic               picked_valid;
  logic [IDXO_W-1:0]  pick_index;
  logic [SUM_W-1:0]   running_sum;
  logic [CNT_W-1:0]   picked_count;
  logic               hit;
  logic               last;

  modport source (output valid, picked_valid, pick_index, running_sum, picked_count, hit,
                  last, input ready);
  modport sink (input valid, picked_valid, pick_index, running_sum, picked_count, hit,
                last, output ready);
endinterface

@@ design/acbc_ctrl.sv @@
module acbc_ctrl
  import acbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_kind,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_DIV   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_PICK  = 6'b010000,
    S_FINAL = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_kind == KIND_COMPOSE) begin
            cmd.start = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.more) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_FINAL;
        end
      end
      S_DIV: begin
        if (!sts.div_busy) begin
          cmd.scan_start = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (!sts.sel_found) begin
          state_next = S_FINAL;
        end else if (!(sts.pend_valid && sts.out_busy)) begin
          cmd.pick = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_FINAL: begin
        if (!sts.out_busy) begin
          cmd.emit_final = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/acbc_dpath.sv @@
module acbc_dpath
  import acbc_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [FP_W-1:0]      entry_footprint,
  input  logic [AGE_W-1:0]     entry_age,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  acbc_rsp_if.source           rsp
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int DIV_STEPS = SUM_W;

  logic [AGE_W-1:0]  age_cap;
  logic [CNT_W-1:0]  count_target;
  logic [TSUM_W-1:0] target_sum;

  logic [FP_W-1:0]  fp_mem [POOL_DEPTH];
  logic [AGE_W-1:0] age_mem [POOL_DEPTH];
  logic             used_mem [POOL_DEPTH];

  logic [IDX_W:0]   pool_size;
  logic             fresh_pool;

  logic [CNT_W-1:0] n;
  logic [SUM_W-1:0] sum;
  logic             pend_valid;
  logic [IDX_W-1:0] pend_idx;

  logic [7:0]       rem;
  logic [7:0]       dsr;
  logic [SUM_W-1:0] dvd;
  logic [SUM_W-1:0] quot;
  logic [5:0]       div_cnt;
  logic             div_busy;

  logic [IDX_W:0]   addr;
  logic             scan_busy;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;
  logic [FP_W-1:0]  fp_q;
  logic [AGE_W-1:0] age_q;
  logic             used_q;

  logic             age_found;
  logic [IDX_W-1:0] age_idx;
  logic [FP_W-1:0]  age_fp;
  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  logic [FP_W-1:0]  best_fp;
  logic [SUM_W-1:0] best_d;

  logic             out_valid;
  logic             out_picked;
  logic [IDX_W-1:0] out_idx;
  logic [SUM_W-1:0] out_sum;
  logic [CNT_W-1:0] out_cnt;
  logic             out_hit;
  logic             out_last;

  logic             load_ok;
  logic [IDX_W-1:0] load_addr;
  logic [IDX_W:0]   load_base;
  logic             issue;
  logic [8:0]       div_t;
  logic             div_ge;
  logic [SUM_W-1:0] fp_ext;
  logic [SUM_W-1:0] fp_dev;
  logic [IDX_W-1:0] sel_idx;
  logic [FP_W-1:0]  sel_fp;
  logic [CNT_W-1:0] limit;
  logic [SUM_W-1:0] tsum_ext;
  logic [SUM_W-1:0] dev;
  logic [CNT_W-1:0] cdiff;
  logic [SUM_W+3:0] dev10;
  logic             hit_now;
  logic [IDX_W+IDXO_W-1:0] idx_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      age_cap <= AGE_W'(5);
      count_target <= CNT_W'(62);
      target_sum <= TSUM_W'(6150000);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AGE_CAP:      age_cap <= cfg_data[AGE_W-1:0];
        REG_COUNT_TARGET: count_target <= cfg_data[CNT_W-1:0];
        REG_TARGET_SUM:   target_sum <= cfg_data[TSUM_W-1:0];
        default: ;
      endcase
    end
  end

  assign load_base = fresh_pool ? '0 : pool_size;
  assign load_ok   = fresh_pool || (pool_size < (IDX_W+1)'(POOL_DEPTH));
  assign load_addr = load_base[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size <= '0;
      fresh_pool <= 1'b1;
    end else if (cmd.load) begin
      fresh_pool <= 1'b0;
      if (load_ok) begin
        pool_size <= load_base + 1'b1;
      end
    end else if (cmd.start) begin
      fresh_pool <= 1'b1;
    end
  end

  // A load clears the mark of the entry it writes, so a new pool needs no sweep.
  always_ff @(posedge clk) begin
    if (cmd.load && load_ok) begin
      fp_mem[load_addr] <= entry_footprint;
      age_mem[load_addr] <= entry_age;
    end
    if (cmd.load && load_ok) begin
      used_mem[load_addr] <= 1'b0;
    end else if (cmd.pick) begin
      used_mem[sel_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    fp_q <= fp_mem[addr[IDX_W-1:0]];
    age_q <= age_mem[addr[IDX_W-1:0]];
    used_q <= used_mem[addr[IDX_W-1:0]];
  end

  // The ideal footprint is round(num / den), taken as (2*num + den) / (2*den).
  assign div_t  = {rem, dvd[SUM_W-1]};
  assign div_ge = div_t >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
    end else if (div_busy && div_cnt == 6'd1) begin
      div_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd <= {1'b0, target_sum - sum[TSUM_W-1:0], 1'b0}
             + SUM_W'(count_target - n);
      dsr <= {count_target - n, 1'b0};
      rem <= '0;
      quot <= '0;
      div_cnt <= 6'(DIV_STEPS);
    end else if (div_busy) begin
      rem <= div_ge ? 8'(div_t - {1'b0, dsr}) : div_t[7:0];
      quot <= {quot[SUM_W-2:0], div_ge};
      dvd <= {dvd[SUM_W-2:0], 1'b0};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  assign issue  = scan_busy && (addr < pool_size);
  assign fp_ext = SUM_W'(fp_q);
  assign fp_dev = (fp_ext > quot) ? fp_ext - quot : quot - fp_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_busy <= 1'b0;
      rd_valid <= 1'b0;
      addr <= '0;
    end else if (cmd.scan_start) begin
      scan_busy <= 1'b1;
      rd_valid <= 1'b0;
      addr <= '0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        addr <= addr + 1'b1;
      end else begin
        scan_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= addr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      age_found <= 1'b0;
      best_found <= 1'b0;
    end else if (rd_valid && !used_q) begin
      if (!age_found && age_q >= age_cap) begin
        age_found <= 1'b1;
        age_idx <= rd_idx;
        age_fp <= fp_q;
      end
      if (!best_found || fp_dev < best_d) begin
        best_found <= 1'b1;
        best_idx <= rd_idx;
        best_fp <= fp_q;
        best_d <= fp_dev;
      end
    end
  end

  assign sel_idx = age_found ? age_idx : best_idx;
  assign sel_fp  = age_found ? age_fp : best_fp;

  assign limit    = (count_target > CNT_W'(MAX_PICKS)) ? CNT_W'(MAX_PICKS) : count_target;
  assign tsum_ext = SUM_W'(target_sum);
  assign dev      = (sum > tsum_ext) ? sum - tsum_ext : tsum_ext - sum;
  assign cdiff    = (n > count_target) ? n - count_target : count_target - n;
  assign dev10    = ({4'd0, dev} << 3) + ({4'd0, dev} << 1);
  assign hit_now  = (cdiff <= CNT_W'(HIT_COUNT_TOL)) && (dev10 <= (SUM_W+4)'(target_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (cmd.start || cmd.emit_final) begin
      pend_valid <= 1'b0;
    end else if (cmd.pick) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      n <= '0;
      sum <= '0;
    end else if (cmd.pick) begin
      n <= n + 1'b1;
      sum <= sum + SUM_W'(sel_fp);
      pend_idx <= sel_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.pick && pend_valid) || cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick && pend_valid) begin
      out_picked <= 1'b1;
      out_idx <= pend_idx;
      out_sum <= sum;
      out_cnt <= n;
      out_hit <= 1'b0;
      out_last <= 1'b0;
    end else if (cmd.emit_final) begin
      out_picked <= pend_valid;
      out_idx <= pend_valid ? pend_idx : '0;
      out_sum <= pend_valid ? sum : '0;
      out_cnt <= pend_valid ? n : '0;
      out_hit <= hit_now;
      out_last <= 1'b1;
    end
  end

  assign idx_ext = {{IDXO_W{1'b0}}, out_idx};

  assign rsp.valid        = out_valid;
  assign rsp.picked_valid = out_picked;
  assign rsp.pick_index   = idx_ext[IDXO_W-1:0];
  assign rsp.running_sum  = out_sum;
  assign rsp.picked_count = out_cnt;
  assign rsp.hit          = out_hit;
  assign rsp.last         = out_last;

  assign sts.div_busy   = div_busy;
  assign sts.scan_done  = !scan_busy && !rd_valid;
  assign sts.sel_found  = age_found || best_found;
  assign sts.more       = (n < limit) && (sum < tsum_ext);
  assign sts.pend_valid = pend_valid;
  assign sts.out_busy   = out_valid;

endmodule

@@ design/age_capped_batch_composer.sv @@
// A load request produces no response.
// A compose request runs, for each pick, a rounding divider and then one pool memory
// read per entry.
// Throughput is one request at a time; responses wait in an output register for ready.
// Synchronous active-high reset clears the pool size and control, and loads the register
// defaults; pool contents and used marks are undefined until loaded.
module age_capped_batch_composer
  import acbc_pkg::*;
#(
  parameter int POOL_DEPTH = POOL_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  acbc_req_if.sink             req,
  acbc_rsp_if.source           rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign req.ready = in_ready;

  acbc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_kind  (req.kind),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  acbc_dpath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .entry_footprint (req.entry_footprint),
    .entry_age       (req.entry_age),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .sts             (sts),
    .rsp             (rsp)
  );

endmodule
